/* sv/sxet_pkg.sv */
// Shared types and constants for the horizontal Sobel edge threshold block.
package sxet_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned CFG_W    = 11;
	localparam int unsigned THRESH_W = 7;
	localparam int unsigned POS_W    = 20;
	localparam int unsigned SUM_W    = 11;
	localparam int unsigned QUOT_W   = SUM_W - 3;

	localparam logic [CFG_W-1:0]    LINE_WIDTH_RST   = 11'd640;
	localparam logic [CFG_W-1:0]    FRAME_HEIGHT_RST = 11'd480;
	localparam logic [THRESH_W-1:0] THRESHOLD_RST    = 7'd20;

	localparam logic [SAMPLE_W-1:0] LEVEL_EDGE = 8'hFF;
	localparam logic [SAMPLE_W-1:0] LEVEL_NONE = 8'h00;

	localparam logic [SUM_W-1:0] ROUND_NEG = 11'd7;

	typedef enum logic [1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_THRESHOLD    = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_t;

endpackage

/* sv/sobel_x_edge_threshold.sv */
// Top level of the horizontal Sobel edge threshold block on a raster pixel stream.

// One pixel beat is accepted every clock cycle while the skid register is
// empty. Each beat reads one entry of a line store memory (MAX_WIDTH entries of
// two bytes, upper and middle row) at its column, and the shifted pair is written
// back from the stage-one registers; a beat that reads the entry still being
// written takes the new pair directly. The 3x3 window and the kernel sum, and
// then the threshold, follow in two further pipeline stages (stage two and the
// output register). Results appear W+1 beats after their centre pixel; centres
// in the first row and the first pixel of the second row give 0, and the last
// W+1 centres of a frame are not emitted. A skid register behind the output
// register lets the input keep running for one stalled result. The line store
// is not cleared after reset. Register writes take effect from the next beat and
// are to be made only while no beat is in flight; the block does not enforce this.
module sobel_x_edge_threshold #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// red_sample [7:0]
	input  logic [sxet_pkg::SAMPLE_W-1:0]        s_tdata,
	// first_of_frame [0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// edge_level [7:0]
	output logic [sxet_pkg::SAMPLE_W-1:0]        m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [sxet_pkg::CFG_W-1:0]           cfg_data
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned TW = WW + HW;
	localparam int unsigned SW = sxet_pkg::SAMPLE_W;
	localparam int unsigned PW = sxet_pkg::POS_W;
	localparam int unsigned QW = sxet_pkg::QUOT_W;

	logic [sxet_pkg::CFG_W-1:0]    line_width_q;
	logic [sxet_pkg::CFG_W-1:0]    frame_height_q;
	logic [sxet_pkg::THRESH_W-1:0] threshold_q;

	logic [WW-1:0] width_cur;
	logic [HW-1:0] height_cur;
	logic [TW-1:0] total_cur;

	logic [AW-1:0] column_q;
	logic [PW-1:0] pos_q;
	logic          done_q;

	logic [2*SW-1:0] line_mem [MAX_WIDTH];
	logic [2*SW-1:0] rd_q;

	logic          valid_s1;
	logic [SW-1:0] sample_s1;
	logic [AW-1:0] column_s1;
	logic          emit_s1;
	logic          border_s1;
	logic          last_s1;

	logic [SW-1:0] tap_up_q  [2];
	logic [SW-1:0] tap_mid_q [2];
	logic [SW-1:0] tap_low_q [2];

	logic                               valid_s2;
	logic signed [sxet_pkg::SUM_W-1:0]  sum_s2;
	logic                               border_s2;
	logic                               last_s2;

	logic          out_valid_q;
	logic [SW-1:0] out_level_q;
	logic          out_last_q;
	logic          skid_valid_q;
	logic [SW-1:0] skid_level_q;
	logic          skid_last_q;

	logic          en;
	logic          accept;
	logic          out_take;
	logic [AW-1:0] col_eff;
	logic [AW-1:0] col_next;
	logic [WW-1:0] col_inc;
	logic [PW-1:0] pos_eff;
	logic          done_eff;
	logic          emit;
	logic          border;
	logic          last;

	logic [SW-1:0] up_rd;
	logic [SW-1:0] mid_rd;
	logic signed [sxet_pkg::SUM_W-1:0] sum_s1;
	logic signed [sxet_pkg::SUM_W-1:0] sum_adj;
	logic signed [QW-1:0]              quot;
	logic signed [QW-1:0]              thr_pos;
	logic signed [QW-1:0]              thr_neg;
	logic [SW-1:0]                     level_s2;

	logic [31:0] width_raw;
	logic [31:0] height_raw;

	assign en       = !skid_valid_q;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign out_take = out_valid_q && m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_level_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= sxet_pkg::LINE_WIDTH_RST;
			frame_height_q <= sxet_pkg::FRAME_HEIGHT_RST;
			threshold_q    <= sxet_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (sxet_pkg::cfg_reg_t'(cfg_index))
				sxet_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				sxet_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				sxet_pkg::REG_THRESHOLD:    threshold_q    <= cfg_data[sxet_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the geometry registers into the supported range.
	always_comb begin
		width_raw  = 32'(line_width_q);
		height_raw = 32'(frame_height_q);
		if (width_raw < 32'd3) begin
			width_raw = 32'd3;
		end else if (width_raw > 32'(MAX_WIDTH)) begin
			width_raw = 32'(MAX_WIDTH);
		end
		if (height_raw < 32'd3) begin
			height_raw = 32'd3;
		end else if (height_raw > 32'(MAX_HEIGHT)) begin
			height_raw = 32'(MAX_HEIGHT);
		end
	end

	assign width_cur  = WW'(width_raw);
	assign height_cur = HW'(height_raw);
	assign total_cur  = TW'(width_cur) * TW'(height_cur);

	always_comb begin
		pos_eff  = s_tuser ? '0 : pos_q;
		done_eff = s_tuser ? 1'b0 : done_q;
		col_eff  = (s_tuser || (column_q >= width_cur)) ? '0 : column_q;
		col_inc  = WW'(col_eff) + WW'(1);
		col_next = (col_inc >= width_cur) ? '0 : col_inc[AW-1:0];
		emit     = !done_eff && (pos_eff > width_cur) && (pos_eff < total_cur);
		border   = pos_eff <= {width_cur, 1'b1};
		last     = (pos_eff + (TW+1)'(1)) == (TW+1)'(total_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			pos_q    <= '0;
			done_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			if (accept) begin
				column_q <= col_next;
				pos_q    <= (pos_eff != '1) ? pos_eff + PW'(1) : pos_eff;
				done_q   <= done_eff || (emit && last);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (valid_s1 && (column_s1 == col_eff)) begin
				rd_q <= {rd_q[SW-1:0], sample_s1};
			end else begin
				rd_q <= line_mem[col_eff];
			end
			sample_s1 <= s_tdata;
			column_s1 <= col_eff;
			emit_s1   <= emit;
			border_s1 <= border;
			last_s1   <= last;
		end
		if (en && valid_s1) begin
			line_mem[column_s1] <= {rd_q[SW-1:0], sample_s1};
		end
	end

	assign up_rd  = rd_q[2*SW-1:SW];
	assign mid_rd = rd_q[SW-1:0];

	// Right column minus left column of the window after this pixel shifts in.
	assign sum_s1 = $signed({3'b000, up_rd}) - $signed({3'b000, tap_up_q[1]})
		+ (($signed({3'b000, mid_rd}) - $signed({3'b000, tap_mid_q[1]})) <<< 1)
		+ $signed({3'b000, sample_s1}) - $signed({3'b000, tap_low_q[1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_up_q[0]  <= '0;
			tap_up_q[1]  <= '0;
			tap_mid_q[0] <= '0;
			tap_mid_q[1] <= '0;
			tap_low_q[0] <= '0;
			tap_low_q[1] <= '0;
			valid_s2     <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && emit_s1;
			if (valid_s1) begin
				tap_up_q[1]  <= tap_up_q[0];
				tap_up_q[0]  <= up_rd;
				tap_mid_q[1] <= tap_mid_q[0];
				tap_mid_q[0] <= mid_rd;
				tap_low_q[1] <= tap_low_q[0];
				tap_low_q[0] <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2    <= sum_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
	end

	// Division by eight rounds toward zero, so negative sums are biased first.
	always_comb begin
		sum_adj  = sum_s2[sxet_pkg::SUM_W-1] ? sum_s2 + $signed(sxet_pkg::ROUND_NEG) : sum_s2;
		quot     = sum_adj[sxet_pkg::SUM_W-1:3];
		thr_pos  = $signed({1'b0, threshold_q});
		thr_neg  = -thr_pos;
		level_s2 = (!border_s2 && ((quot > thr_pos) || (quot < thr_neg)))
			? sxet_pkg::LEVEL_EDGE : sxet_pkg::LEVEL_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s2) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_level_q <= skid_level_q;
				out_last_q  <= skid_last_q;
			end
		end else if (valid_s2) begin
			if (!out_valid_q || out_take) begin
				out_level_q <= level_s2;
				out_last_q  <= last_s2;
			end else begin
				skid_level_q <= level_s2;
				skid_last_q  <= last_s2;
			end
		end
	end

endmodule
